@@ hw/rtl/bws_pkg.sv @@
// ----------------------------------------------------------------------------
// bws_pkg
// Shared types and constants for the line stepper: coordinate type, register
// map, the configuration bundle, the input item and the result item.
// ----------------------------------------------------------------------------
package bws_pkg;

  localparam int COORD_W = 16;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_END_X   = 3'd2,
    REG_END_Y   = 3'd3,
    REG_X_SPEED = 3'd4,
    REG_Y_SPEED = 3'd5
  } reg_idx_t;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    coord_t x_speed;
    coord_t y_speed;
  } cfg_t;

  typedef struct packed {
    logic command;
    logic snap_x;
    logic snap_y;
  } item_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   done_res;
  } res_t;

endpackage

@@ hw/rtl/bws_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// bws_cfg_regs
// APB-style register file holding the walk start, end and step sizes.
// ----------------------------------------------------------------------------
module bws_cfg_regs
  import bws_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;
  coord_t   wval;
  coord_t   rval;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign wval   = coord_t'(pwdata[COORD_W-1:0]);
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START_X: cfg_nxt.start_x = wval;
        REG_START_Y: cfg_nxt.start_y = wval;
        REG_END_X:   cfg_nxt.end_x   = wval;
        REG_END_Y:   cfg_nxt.end_y   = wval;
        REG_X_SPEED: cfg_nxt.x_speed = wval;
        REG_Y_SPEED: cfg_nxt.y_speed = wval;
        default:     cfg_nxt         = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_X: rval = cfg_r.start_x;
      REG_START_Y: rval = cfg_r.start_y;
      REG_END_X:   rval = cfg_r.end_x;
      REG_END_Y:   rval = cfg_r.end_y;
      REG_X_SPEED: rval = cfg_r.x_speed;
      REG_Y_SPEED: rval = cfg_r.y_speed;
      default:     rval = '0;
    endcase
  end

  assign prdata = {{(DATA_W-COORD_W){1'b0}}, rval};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hw/rtl/bws_step_core.sv @@
// ----------------------------------------------------------------------------
// bws_step_core
// Walk state and the combinational start / step datapath. State advances on
// each fire; the result for the fired item is presented combinationally.
// ----------------------------------------------------------------------------
module bws_step_core
  import bws_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  coord_t cur_x_r,  cur_x_nxt;
  coord_t cur_y_r,  cur_y_nxt;
  coord_t move_x_r, move_x_nxt;
  coord_t move_y_r, move_y_nxt;
  coord_t dist_x_r, dist_x_nxt;
  coord_t dist_y_r, dist_y_nxt;
  coord_t acc_r,    acc_nxt;
  coord_t end_x_r,  end_x_nxt;
  coord_t end_y_r,  end_y_nxt;

  always_comb begin
    coord_t dx;
    coord_t dy;
    logic   major_x;
    coord_t acc_sum;
    coord_t maj_dist;
    logic   minor_step;
    coord_t x_new;
    coord_t y_new;
    logic   arr_x;
    logic   arr_y;

    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    move_x_nxt = move_x_r;
    move_y_nxt = move_y_r;
    dist_x_nxt = dist_x_r;
    dist_y_nxt = dist_y_r;
    acc_nxt    = acc_r;
    end_x_nxt  = end_x_r;
    end_y_nxt  = end_y_r;
    res        = '0;

    // start path
    dx = cfg.end_x - cfg.start_x;
    dy = cfg.end_y - cfg.start_y;

    // step path
    major_x    = dist_x_r > dist_y_r;
    acc_sum    = acc_r + (major_x ? dist_y_r : dist_x_r);
    maj_dist   = major_x ? dist_x_r : dist_y_r;
    minor_step = acc_sum > maj_dist;
    x_new      = cur_x_r + ((major_x || minor_step) ? move_x_r : coord_t'(0));
    y_new      = cur_y_r + ((!major_x || minor_step) ? move_y_r : coord_t'(0));
    arr_x = ((move_x_r > 0) && (x_new >= end_x_r)) ||
            ((move_x_r < 0) && (x_new <= end_x_r));
    arr_y = ((move_y_r > 0) && (y_new >= end_y_r)) ||
            ((move_y_r < 0) && (y_new <= end_y_r));

    if (item.command == CMD_START) begin
      cur_x_nxt  = cfg.start_x;
      cur_y_nxt  = cfg.start_y;
      end_x_nxt  = cfg.end_x;
      end_y_nxt  = cfg.end_y;
      // flip distance and move where the end lies below the start
      dist_x_nxt = dx[COORD_W-1] ? -dx : dx;
      move_x_nxt = dx[COORD_W-1] ? -cfg.x_speed : cfg.x_speed;
      dist_y_nxt = dy[COORD_W-1] ? -dy : dy;
      move_y_nxt = dy[COORD_W-1] ? -cfg.y_speed : cfg.y_speed;
      acc_nxt    = '0;
      res.done_res = 1'b0;
    end else begin
      cur_x_nxt  = (arr_x && item.snap_x) ? end_x_r : x_new;
      cur_y_nxt  = (arr_y && item.snap_y) ? end_y_r : y_new;
      acc_nxt    = minor_step ? acc_sum - maj_dist : acc_sum;
      res.done_res = arr_x && arr_y;
    end
    res.point_x = cur_x_nxt;
    res.point_y = cur_y_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      move_x_r <= '0;
      move_y_r <= '0;
      dist_x_r <= '0;
      dist_y_r <= '0;
      acc_r    <= '0;
      end_x_r  <= '0;
      end_y_r  <= '0;
    end else if (fire) begin
      cur_x_r  <= cur_x_nxt;
      cur_y_r  <= cur_y_nxt;
      move_x_r <= move_x_nxt;
      move_y_r <= move_y_nxt;
      dist_x_r <= dist_x_nxt;
      dist_y_r <= dist_y_nxt;
      acc_r    <= acc_nxt;
      end_x_r  <= end_x_nxt;
      end_y_r  <= end_y_nxt;
    end
  end

endmodule

@@ hw/rtl/bresenham_wipe_stepper.sv @@
// Path: input register, step core, then output register driving out_*.
// Throughput: one item per cycle while out_stall is low; the step datapath
//   between the registers closes the walk-state loop combinationally.
// Reset (rst_n low, synchronous): both pipeline registers empty, registers
//   and walk state zero.
// ----------------------------------------------------------------------------
// bresenham_wipe_stepper
// Line stepper top level: input register, step core, output register and
// the APB-style configuration port.
// ----------------------------------------------------------------------------
module bresenham_wipe_stepper
  import bws_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_command,
  input  logic                     in_snap_x,
  input  logic                     in_snap_y,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [COORD_W-1:0] out_point_x,
  output logic signed [COORD_W-1:0] out_point_y,
  output logic                     out_done_res
);

  cfg_t  cfg;
  item_t s1_item_r;
  logic  s1_valid_r, s1_valid_nxt;
  res_t  res;
  res_t  out_res_r;
  logic  out_valid_r, out_valid_nxt;
  logic  out_adv;
  logic  fire;
  logic  in_acc;

  bws_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bws_step_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (s1_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_adv  = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_acc || (s1_valid_r && !fire);
    out_valid_nxt = fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= '{command: in_command, snap_x: in_snap_x, snap_y: in_snap_y};
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_point_x  = out_res_r.point_x;
  assign out_point_y  = out_res_r.point_y;
  assign out_done_res = out_res_r.done_res;

endmodule

@@ hw/rtl/bws_checker.sv @@
// ----------------------------------------------------------------------------
// bws_checker
// Port-level checks for the line stepper, bound to the top level.
// ----------------------------------------------------------------------------
module bws_checker
  import bws_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_command,
  input logic               out_valid,
  input logic               out_stall,
  input logic [COORD_W-1:0] out_point_x,
  input logic [COORD_W-1:0] out_point_y,
  input logic               out_done_res
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_x) &&
      $stable(out_point_y) && $stable(out_done_res))
    else $error("stalled result beat changed");

  // input backpressure only arises from a stalled, full output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output free");

  // a start beat held in the input register while out_stall is low reaches the output with done clear
  a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_command == CMD_START) ##1 !out_stall
      |=> out_valid && !out_done_res)
    else $error("start result missing or flagged done");

  // result valid drops only after a taken beat
  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> !$past(out_stall))
    else $error("result beat dropped while stalled");

endmodule

bind bresenham_wipe_stepper bws_checker u_bws_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_command   (in_command),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_point_x  (out_point_x),
  .out_point_y  (out_point_y),
  .out_done_res (out_done_res)
);

@@ verif/bws_walk_checker.sv @@
// ----------------------------------------------------------------------------
// bws_walk_checker
// Watches the register port and both item channels of the line stepper. It
// keeps its own copy of the registers and the walk state, works out the
// point and done flag for every accepted input beat, and compares each
// result beat field by field against the oldest pending point.
// ----------------------------------------------------------------------------
module bws_walk_checker
  import bws_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  input  logic                      pready,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      in_command,
  input  logic                      in_snap_x,
  input  logic                      in_snap_y,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COORD_W-1:0] out_point_x,
  input  logic signed [COORD_W-1:0] out_point_y,
  input  logic                      out_done_res,
  output int                        fail_count,
  output int                        res_seen,
  output int                        pending
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t   regs;
  coord_t walk_x, walk_y, move_x, move_y, span_x, span_y, err_acc, goal_x, goal_y;
  res_t   point_q[$];
  int     errors;
  int     seen;

  initial begin
    errors = 0;
    seen   = 0;
  end

  function automatic logic reached(coord_t mv, coord_t pos, coord_t goal);
    return (mv > 0 && pos >= goal) || (mv < 0 && pos <= goal);
  endfunction

  // Walk state is updated in place, as the block does it.
  function automatic res_t next_point(item_t it);
    res_t r;
    int   hits;
    hits = 0;
    if (it.command == CMD_START) begin
      walk_x  = regs.start_x;
      walk_y  = regs.start_y;
      goal_x  = regs.end_x;
      goal_y  = regs.end_y;
      move_x  = regs.x_speed;
      move_y  = regs.y_speed;
      span_x  = regs.end_x - regs.start_x;
      span_y  = regs.end_y - regs.start_y;
      // a span of -32768 negates to itself and stays negative
      if (span_x < 0) begin
        span_x = -span_x;
        move_x = -regs.x_speed;
      end
      if (span_y < 0) begin
        span_y = -span_y;
        move_y = -regs.y_speed;
      end
      err_acc = '0;
    end else begin
      if (span_x > span_y) begin
        walk_x  = walk_x + move_x;
        err_acc = err_acc + span_y;
        if (err_acc > span_x) begin
          walk_y  = walk_y + move_y;
          err_acc = err_acc - span_x;
        end
      end else begin
        walk_y  = walk_y + move_y;
        err_acc = err_acc + span_x;
        if (err_acc > span_y) begin
          walk_x  = walk_x + move_x;
          err_acc = err_acc - span_y;
        end
      end
      if (reached(move_x, walk_x, goal_x)) begin
        hits++;
        if (it.snap_x) walk_x = goal_x;
      end
      if (reached(move_y, walk_y, goal_y)) begin
        hits++;
        if (it.snap_y) walk_y = goal_y;
      end
    end
    r.point_x  = walk_x;
    r.point_y  = walk_y;
    r.done_res = (hits == 2);
    return r;
  endfunction

  always @(posedge clk) begin
    item_t it;
    res_t  want;
    if (!rst_n) begin
      regs    = '0;
      walk_x  = '0;
      walk_y  = '0;
      move_x  = '0;
      move_y  = '0;
      span_x  = '0;
      span_y  = '0;
      err_acc = '0;
      goal_x  = '0;
      goal_y  = '0;
      point_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[4:2]))
          REG_START_X: regs.start_x = pwdata[COORD_W-1:0];
          REG_START_Y: regs.start_y = pwdata[COORD_W-1:0];
          REG_END_X:   regs.end_x   = pwdata[COORD_W-1:0];
          REG_END_Y:   regs.end_y   = pwdata[COORD_W-1:0];
          REG_X_SPEED: regs.x_speed = pwdata[COORD_W-1:0];
          REG_Y_SPEED: regs.y_speed = pwdata[COORD_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen++;
        if (point_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing pending: x %0d y %0d done %0b",
                   $time, out_point_x, out_point_y, out_done_res);
        end else begin
          want = point_q.pop_front();
          if (out_point_x !== want.point_x) begin
            errors++;
            $display("%0t: point_x expected %0d got %0d", $time, want.point_x,
                     out_point_x);
          end
          if (out_point_y !== want.point_y) begin
            errors++;
            $display("%0t: point_y expected %0d got %0d", $time, want.point_y,
                     out_point_y);
          end
          if (out_done_res !== want.done_res) begin
            errors++;
            $display("%0t: done_res expected %0b got %0b", $time, want.done_res,
                     out_done_res);
          end
        end
      end
      if (in_valid && !in_stall) begin
        it.command = in_command;
        it.snap_x  = in_snap_x;
        it.snap_y  = in_snap_y;
        point_q.push_back(next_point(it));
      end
    end
    fail_count <= errors;
    res_seen   <= seen;
    pending    <= point_q.size();
  end

endmodule

@@ verif/bresenham_wipe_stepper_test.sv @@
// ----------------------------------------------------------------------------
// bresenham_wipe_stepper_test
// Drives register setups and start/step beats into the line stepper with
// random gaps and output stalls, and leaves prediction and comparison to the
// checker. A short directed part covers stepping before any start, extreme
// coordinates, a wrapped distance, zero step sizes, register writes after a
// start and walks running backward; random walks follow.
// ----------------------------------------------------------------------------
module bresenham_wipe_stepper_test
  import bws_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 750;
  localparam int QUIET_LIMIT = 1000;

  logic                      clk     = 1'b0;
  logic                      rst_n   = 1'b0;
  logic                      psel    = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite  = 1'b0;
  logic [ADDR_W-1:0]         paddr   = '0;
  logic [DATA_W-1:0]         pwdata  = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid   = 1'b0;
  logic                      in_stall;
  logic                      in_command = 1'b0;
  logic                      in_snap_x  = 1'b0;
  logic                      in_snap_y  = 1'b0;
  logic                      out_valid;
  logic                      out_stall  = 1'b0;
  logic signed [COORD_W-1:0] out_point_x;
  logic signed [COORD_W-1:0] out_point_y;
  logic                      out_done_res;
  int                        fail_count;
  int                        res_seen;
  int                        pending;

  int items_sent  = 0;
  int walks       = 0;
  int quiet_count = 0;
  bit in_gaps_on  = 1'b0;
  bit stall_on    = 1'b0;

  bresenham_wipe_stepper u_dut (.*);
  bws_walk_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic cfg_t mk_cfg(int sx, int sy, int ex, int ey, int vx, int vy);
    cfg_t c;
    c.start_x = coord_t'(sx);
    c.start_y = coord_t'(sy);
    c.end_x   = coord_t'(ex);
    c.end_y   = coord_t'(ey);
    c.x_speed = coord_t'(vx);
    c.y_speed = coord_t'(vy);
    return c;
  endfunction

  function automatic coord_t any_coord();
    case ($urandom_range(0, 4))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return '0;
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic coord_t walk_speed();
    coord_t v;
    v = coord_t'($urandom_range(1, 4));
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return -v;
      default: return v;
    endcase
  endfunction

  // Mostly short walks that arrive; some fully random setups.
  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.start_x = coord_t'($urandom());
    c.start_y = coord_t'($urandom());
    if ($urandom_range(0, 9) < 7) begin
      c.end_x   = c.start_x + coord_t'(int'($urandom_range(0, 60)) - 30);
      c.end_y   = c.start_y + coord_t'(int'($urandom_range(0, 60)) - 30);
      c.x_speed = walk_speed();
      c.y_speed = walk_speed();
    end else begin
      c.start_x = any_coord();
      c.start_y = any_coord();
      c.end_x   = any_coord();
      c.end_y   = any_coord();
      c.x_speed = any_coord();
      c.y_speed = any_coord();
    end
    return c;
  endfunction

  task automatic load_regs(input cfg_t c, input logic [5:0] mask);
    reg_idx_t idx;
    coord_t   val;
    for (int i = 0; i < 6; i++) begin
      if (mask[i]) begin
        idx = reg_idx_t'(i);
        case (idx)
          REG_START_X: val = c.start_x;
          REG_START_Y: val = c.start_y;
          REG_END_X:   val = c.end_x;
          REG_END_Y:   val = c.end_y;
          REG_X_SPEED: val = c.x_speed;
          default:     val = c.y_speed;
        endcase
        psel   <= 1'b1;
        pwrite <= 1'b1;
        paddr  <= {idx, 2'b00};
        pwdata <= {16'($urandom()), val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  // Leaves valid high on return so the next beat can follow without a gap.
  task automatic send_item(input logic cmd, input logic sx, input logic sy);
    int gap;
    gap = in_gaps_on ? idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_snap_x  <= sx;
    in_snap_y  <= sy;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic run_walk(input bit do_start, input int n_steps, input bit noisy);
    if (do_start) send_item(CMD_START, 1'($urandom()), 1'($urandom()));
    repeat (n_steps) begin
      // restart in the middle of a walk now and then
      if (noisy && $urandom_range(0, 19) == 0)
        send_item(CMD_START, 1'($urandom()), 1'($urandom()));
      else
        send_item(CMD_STEP, 1'($urandom()), 1'($urandom()));
    end
    in_valid <= 1'b0;
    walks++;
    while (res_seen < items_sent) @(posedge clk);
  endtask

  always begin : stall_gen
    int n;
    n = idle_len();
    if (stall_on && n > 0) begin
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
    out_stall <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("bresenham_wipe_stepper verification failed");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin : stimulus
    logic [5:0] mask;
    bit         do_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed walks
    in_gaps_on = 1'b1;
    stall_on   = 1'b1;
    run_walk(1'b0, 2, 1'b0);
    load_regs(mk_cfg(0, 0, 10, 4, 1, 1), 6'h3f);
    run_walk(1'b1, 7, 1'b0);
    load_regs(mk_cfg(32767, -32768, -32768, 32767, -32768, 32767), 6'h3f);
    run_walk(1'b1, 2, 1'b0);
    load_regs(mk_cfg(0, 0, -32768, 5, 0, 0), 6'h3f);
    run_walk(1'b1, 2, 1'b0);
    // new end point must not matter until the next start
    load_regs(mk_cfg(0, 0, 3, 3, 1, 1), 6'b111100);
    run_walk(1'b0, 2, 1'b0);
    load_regs(mk_cfg(20, -5, 14, -9, 2, 1), 6'h3f);
    run_walk(1'b1, 4, 1'b0);

    // random walks
    while (items_sent < ITEM_TARGET) begin
      in_gaps_on = ($urandom_range(0, 3) != 0);
      stall_on   = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 19))
        0, 1, 2:       mask = '0;
        3, 4, 5, 6, 7: mask = 6'($urandom_range(1, 63));
        default:       mask = 6'h3f;
      endcase
      do_start = (mask == '0) ? 1'($urandom()) : ($urandom_range(0, 9) != 0);
      load_regs(rand_cfg(), mask);
      run_walk(do_start, $urandom_range(3, 45), 1'b1);
    end

    repeat (8) @(posedge clk);
    $display("%0d beats over %0d walks, %0d results compared", items_sent, walks,
             res_seen);
    $display("register setups included extremes, wrapped spans and zero speeds");
    if (fail_count == 0 && pending == 0) begin
      $display("bresenham_wipe_stepper verification clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, pending);
      $display("bresenham_wipe_stepper verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/bws_pkg.sv
hw/rtl/bws_cfg_regs.sv
hw/rtl/bws_step_core.sv
hw/rtl/bresenham_wipe_stepper.sv
hw/rtl/bws_checker.sv
verif/bws_walk_checker.sv
verif/bresenham_wipe_stepper_test.sv
